### hw/rtl/assert_macros.svh
// Assertion macros shared by the execute unit RTL.
// No dependencies; compile NO_ASSERTIONS to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("%m: check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/mie_pkg.sv
// Types and operation codes for the MIPS I integer execute unit.
// No dependencies.
package mie_pkg;
  localparam logic [5:0] OP_LB = 6'd0, OP_LBU = 6'd1, OP_LH = 6'd2, OP_LHU = 6'd3,
    OP_LW = 6'd4, OP_LWL = 6'd5, OP_LWR = 6'd6, OP_SB = 6'd7, OP_SH = 6'd8,
    OP_SW = 6'd9, OP_SWL = 6'd10, OP_SWR = 6'd11, OP_ADDI = 6'd12, OP_ADDIU = 6'd13,
    OP_SLTI = 6'd14, OP_SLTIU = 6'd15, OP_ANDI = 6'd16, OP_ORI = 6'd17,
    OP_XORI = 6'd18, OP_LUI = 6'd19, OP_ADD = 6'd20, OP_ADDU = 6'd21, OP_SUB = 6'd22,
    OP_SUBU = 6'd23, OP_SLT = 6'd24, OP_SLTU = 6'd25, OP_AND = 6'd26, OP_OR = 6'd27,
    OP_XOR = 6'd28, OP_NOR = 6'd29, OP_NOP = 6'd30, OP_SLL = 6'd31, OP_SRL = 6'd32,
    OP_SRA = 6'd33, OP_SLLV = 6'd34, OP_SRLV = 6'd35, OP_SRAV = 6'd36,
    OP_MULT = 6'd37, OP_MULTU = 6'd38, OP_DIV = 6'd39, OP_DIVU = 6'd40,
    OP_MFHI = 6'd41, OP_MTHI = 6'd42, OP_MFLO = 6'd43, OP_MTLO = 6'd44,
    OP_J = 6'd45, OP_JAL = 6'd46, OP_JR = 6'd47, OP_JALR = 6'd48, OP_BEQ = 6'd49,
    OP_BNE = 6'd50, OP_BLEZ = 6'd51, OP_BGTZ = 6'd52, OP_BLTZ = 6'd53,
    OP_BGEZ = 6'd54, OP_BLTZAL = 6'd55, OP_BGEZAL = 6'd56, OP_SYSCALL = 6'd57,
    OP_BREAK = 6'd58;

  localparam logic [1:0] ST_OK = 2'd0, ST_OVF = 2'd1, ST_HALT = 2'd2, ST_BRK = 2'd3;

  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    logic [25:0] jidx;
    logic        is_mul;
    logic        is_div;
  } dec_t;
endpackage

### hw/rtl/mie_front.sv
// Front end: accepts instruction beats, classifies them, and holds a
// two-entry queue toward the back end. Depends on mie_pkg.
module mie_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [5:0]       op_i,
  input  logic [4:0]       rs_i,
  input  logic [4:0]       rt_i,
  input  logic [4:0]       rd_i,
  input  logic [4:0]       sa_i,
  input  logic [15:0]      imm_i,
  input  logic [25:0]      jidx_i,
  output logic             q_valid_o,
  output mie_pkg::dec_t    q_data_o,
  input  logic             q_pop_i
);
  import mie_pkg::*;

  dec_t       ent_q [2];
  logic [1:0] cnt_q;
  logic       rd_q;
  logic       wr_q;
  logic       push;
  dec_t       dec;

  always_comb begin
    dec.op = op_i; dec.rs = rs_i; dec.rt = rt_i; dec.rd = rd_i;
    dec.sa = sa_i; dec.imm = imm_i; dec.jidx = jidx_i;
    dec.is_mul = (op_i == OP_MULT) || (op_i == OP_MULTU);
    dec.is_div = (op_i == OP_DIV) || (op_i == OP_DIVU);
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0; rd_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= dec;
  end
endmodule

### hw/rtl/mie_muldiv.sv
// Iterative multiply/divide unit: shift-add multiply and restoring divide,
// one bit per cycle. Depends on nothing.
module mie_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        div_i,
  input  logic        sgn_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] hi_o,
  output logic [31:0] lo_o
);
  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        div_q, neg_q, negr_q;
  logic [31:0] acc_q, sh_q, b_q;
  logic [31:0] ua, ub;
  logic [32:0] sum, trial;
  logic [63:0] prod, pneg;
  logic [31:0] qv, rv;

  assign ua = (sgn_i && a_i[31]) ? 32'd0 - a_i : a_i;
  assign ub = (sgn_i && b_i[31]) ? 32'd0 - b_i : b_i;
  assign sum = {1'b0, acc_q} + (sh_q[0] ? {1'b0, b_q} : 33'd0);
  assign trial = {acc_q, sh_q[31]} - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1; cnt_q <= 6'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd32) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i; acc_q <= 32'd0; sh_q <= ua; b_q <= ub;
      neg_q <= sgn_i && (a_i[31] ^ b_i[31]);
      negr_q <= sgn_i && a_i[31];
    end else if (busy_q && cnt_q != 6'd32) begin
      if (div_q) begin
        if (!trial[32]) begin
          acc_q <= trial[31:0]; sh_q <= {sh_q[30:0], 1'b1};
        end else begin
          acc_q <= {acc_q[30:0], sh_q[31]}; sh_q <= {sh_q[30:0], 1'b0};
        end
      end else begin
        acc_q <= sum[32:1]; sh_q <= {sum[0], sh_q[31:1]};
      end
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd32);
  assign prod = {acc_q, sh_q};
  assign pneg = 64'd0 - prod;
  assign qv = neg_q ? 32'd0 - sh_q : sh_q;
  assign rv = negr_q ? 32'd0 - acc_q : acc_q;
  assign hi_o = div_q ? rv : (neg_q ? pneg[63:32] : prod[63:32]);
  assign lo_o = div_q ? qv : (neg_q ? pneg[31:0] : prod[31:0]);
endmodule

### hw/rtl/mie_back.sv
// Back end: register file, hi/lo, pc pair, data memory and the output
// register. Depends on mie_pkg and mie_muldiv.
module mie_back #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          q_valid_i,
  input  mie_pkg::dec_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   next_fetch_pc_o,
  output logic          reg_write_o,
  output logic [4:0]    reg_index_o,
  output logic [31:0]   reg_value_o,
  output logic          mem_write_o,
  output logic [31:0]   mem_address_o,
  output logic [31:0]   mem_data_o,
  output logic [31:0]   hi_value_o,
  output logic [31:0]   lo_value_o,
  output logic [1:0]    status_o
);
  import mie_pkg::*;
  localparam int AW = $clog2(DMEM_WORDS);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EX = 3'd2, S_MD = 3'd3,
    S_OUT = 3'd4;

  logic [2:0]  state_q;
  logic [31:0] gpr_q [32];
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] hi_q, lo_q, pc_q, npc_q;
  logic        halted_q;
  dec_t        ins_q;
  logic [31:0] vs_q, vt_q, w_q;
  logic        out_busy;
  logic        md_start, md_done;
  logic [31:0] md_hi, md_lo;

  logic [31:0] pcn, simm, zimm, wv, md, nnpc, br, r, sub;
  logic        wr, mw, take;
  logic [4:0]  wi;
  logic [1:0]  st;
  logic [4:0]  bsh;
  logic [31:0] hmask_l, lmask_l;

  // a stalled result beat still owns the output register
  assign out_busy = out_valid_o && out_stall_i;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign md_start = (state_q == S_EX) && !out_busy && !halted_q && (ins_q.is_mul ||
                    (ins_q.is_div && vt_q != 32'd0));

  mie_muldiv u_md (
    .clk_i, .rst_ni, .start_i(md_start), .div_i(ins_q.is_div),
    .sgn_i(ins_q.op == OP_MULT || ins_q.op == OP_DIV), .a_i(vs_q), .b_i(vt_q),
    .done_o(md_done), .hi_o(md_hi), .lo_o(md_lo)
  );

  always_comb begin
    pcn = npc_q;
    simm = {{16{ins_q.imm[15]}}, ins_q.imm};
    zimm = {16'd0, ins_q.imm};
    r = vs_q + simm;
    br = pcn + {simm[29:0], 2'b00};
    nnpc = pcn + 32'd4;
    wr = 1'b0; wi = ins_q.rd; wv = 32'd0; mw = 1'b0; md = 32'd0; st = ST_OK;
    take = 1'b0;
    sub = vs_q - vt_q;
    bsh = 5'd0;
    hmask_l = 32'd0; lmask_l = 32'd0;
    unique case (ins_q.op)
      OP_LB, OP_LBU: begin
        bsh = {~r[1:0], 3'b000};
        wv = {24'd0, 8'(w_q >> bsh)};
        if (ins_q.op == OP_LB && wv[7]) wv[31:8] = 24'hFFFFFF;
        wr = 1'b1; wi = ins_q.rt;
      end
      OP_LH, OP_LHU: begin
        wv = {16'd0, r[1] ? w_q[15:0] : w_q[31:16]};
        if (ins_q.op == OP_LH && wv[15]) wv[31:16] = 16'hFFFF;
        wr = 1'b1; wi = ins_q.rt;
      end
      OP_LW: begin wr = 1'b1; wi = ins_q.rt; wv = w_q; end
      OP_LWL: begin
        bsh = {r[1:0], 3'b000};
        lmask_l = ~(32'hFFFFFFFF << bsh);
        wr = 1'b1; wi = ins_q.rt; wv = (w_q << bsh) | (vt_q & lmask_l);
      end
      OP_LWR: begin
        bsh = {~r[1:0], 3'b000};
        hmask_l = ~(32'hFFFFFFFF >> bsh);
        wr = 1'b1; wi = ins_q.rt; wv = (w_q >> bsh) | (vt_q & hmask_l);
      end
      OP_SB: begin
        bsh = {~r[1:0], 3'b000};
        md = (w_q & ~(32'hFF << bsh)) | ({24'd0, vt_q[7:0]} << bsh); mw = 1'b1;
      end
      OP_SH: begin
        md = r[1] ? {w_q[31:16], vt_q[15:0]} : {vt_q[15:0], w_q[15:0]}; mw = 1'b1;
      end
      OP_SW: begin md = vt_q; mw = 1'b1; end
      OP_SWL: begin
        bsh = {r[1:0], 3'b000};
        hmask_l = ~(32'hFFFFFFFF >> bsh);
        md = (vt_q >> bsh) | (w_q & hmask_l); mw = 1'b1;
      end
      OP_SWR: begin
        bsh = {~r[1:0], 3'b000};
        lmask_l = ~(32'hFFFFFFFF << bsh);
        md = (vt_q << bsh) | (w_q & lmask_l); mw = 1'b1;
      end
      OP_ADDI: begin
        if (vs_q[31] == simm[31] && r[31] != vs_q[31]) st = ST_OVF;
        else begin wr = 1'b1; wi = ins_q.rt; wv = r; end
      end
      OP_ADDIU: begin wr = 1'b1; wi = ins_q.rt; wv = r; end
      OP_SLTI: begin wr = 1'b1; wi = ins_q.rt; wv = {31'd0, $signed(vs_q) < $signed(simm)}; end
      OP_SLTIU: begin wr = 1'b1; wi = ins_q.rt; wv = {31'd0, vs_q < simm}; end
      OP_ANDI: begin wr = 1'b1; wi = ins_q.rt; wv = vs_q & zimm; end
      OP_ORI: begin wr = 1'b1; wi = ins_q.rt; wv = vs_q | zimm; end
      OP_XORI: begin wr = 1'b1; wi = ins_q.rt; wv = vs_q ^ zimm; end
      OP_LUI: begin wr = 1'b1; wi = ins_q.rt; wv = {ins_q.imm, 16'd0}; end
      OP_ADD: begin
        wv = vs_q + vt_q;
        if (vs_q[31] == vt_q[31] && wv[31] != vs_q[31]) begin st = ST_OVF; wv = 32'd0; end
        else wr = 1'b1;
      end
      OP_ADDU: begin wr = 1'b1; wv = vs_q + vt_q; end
      OP_SUB, OP_SUBU: begin wr = 1'b1; wv = sub; end
      OP_SLT: begin wr = 1'b1; wv = {31'd0, $signed(vs_q) < $signed(vt_q)}; end
      OP_SLTU: begin wr = 1'b1; wv = {31'd0, vs_q < vt_q}; end
      OP_AND: begin wr = 1'b1; wv = vs_q & vt_q; end
      OP_OR: begin wr = 1'b1; wv = vs_q | vt_q; end
      OP_XOR: begin wr = 1'b1; wv = vs_q ^ vt_q; end
      OP_NOR: begin wr = 1'b1; wv = ~(vs_q | vt_q); end
      OP_SLL: begin wr = 1'b1; wv = vt_q << ins_q.sa; end
      OP_SRL: begin wr = 1'b1; wv = vt_q >> ins_q.sa; end
      OP_SRA: begin wr = 1'b1; wv = 32'($signed(vt_q) >>> ins_q.sa); end
      OP_SLLV: begin wr = 1'b1; wv = vt_q << vs_q[4:0]; end
      OP_SRLV: begin wr = 1'b1; wv = vt_q >> vs_q[4:0]; end
      OP_SRAV: begin wr = 1'b1; wv = 32'($signed(vt_q) >>> vs_q[4:0]); end
      OP_MFHI: begin wr = 1'b1; wv = hi_q; end
      OP_MFLO: begin wr = 1'b1; wv = lo_q; end
      OP_J: nnpc = {pcn[31:28], ins_q.jidx, 2'b00};
      OP_JAL: begin
        wr = 1'b1; wi = 5'd31; wv = pcn + 32'd4;
        nnpc = {pcn[31:28], ins_q.jidx, 2'b00};
      end
      OP_JR: nnpc = vs_q;
      OP_JALR: begin
        nnpc = vs_q; wr = 1'b1; wv = pcn + 32'd4;
        if (ins_q.rd == 5'd0) wi = 5'd31;
      end
      OP_BEQ: take = (vs_q == vt_q);
      OP_BNE: take = (vs_q != vt_q);
      OP_BLEZ: take = (vs_q == 32'd0) || vs_q[31];
      OP_BGTZ: take = !vs_q[31] && (vs_q != 32'd0);
      OP_BLTZ: take = vs_q[31];
      OP_BGEZ: take = !vs_q[31];
      OP_BLTZAL: begin take = vs_q[31]; wr = 1'b1; wi = 5'd31; wv = pcn + 32'd4; end
      OP_BGEZAL: begin take = !vs_q[31]; wr = 1'b1; wi = 5'd31; wv = pcn + 32'd4; end
      OP_SYSCALL: st = ST_HALT;
      OP_BREAK: st = ST_BRK;
      default: ;
    endcase
    if (take) nnpc = br;
    if (!wr || wi == 5'd0) begin wr = 1'b0; wi = 5'd0; wv = 32'd0; end
  end

  logic is_mem;
  assign is_mem = (ins_q.op <= OP_SWR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_o <= 1'b0; halted_q <= 1'b0;
      hi_q <= 32'd0; lo_q <= 32'd0; pc_q <= 32'd0; npc_q <= 32'd4;
      for (int i = 0; i < 32; i++) gpr_q[i] <= 32'd0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_data_i; npc_q <= cfg_data_i + 32'd4;
      end
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i) state_q <= S_RD;
        S_RD: state_q <= S_EX;
        // hold in execute until the previous result beat has left
        S_EX: if (!out_busy) begin
          if (halted_q) begin
            next_fetch_pc_o <= pc_q; reg_write_o <= 1'b0; reg_index_o <= 5'd0;
            reg_value_o <= 32'd0; mem_write_o <= 1'b0; mem_address_o <= 32'd0;
            mem_data_o <= 32'd0; hi_value_o <= hi_q; lo_value_o <= lo_q;
            status_o <= ST_HALT;
            state_q <= S_OUT;
          end else begin
            pc_q <= pcn; npc_q <= nnpc;
            if (wr) gpr_q[wi] <= wv;
            if (ins_q.op == OP_MTHI) hi_q <= vs_q;
            if (ins_q.op == OP_MTLO) lo_q <= vs_q;
            if (ins_q.op == OP_SYSCALL) halted_q <= 1'b1;
            next_fetch_pc_o <= pcn; reg_write_o <= wr; reg_index_o <= wi;
            reg_value_o <= wv; mem_write_o <= mw;
            mem_address_o <= is_mem ? r : 32'd0; mem_data_o <= md;
            hi_value_o <= (ins_q.op == OP_MTHI) ? vs_q : hi_q;
            lo_value_o <= (ins_q.op == OP_MTLO) ? vs_q : lo_q;
            status_o <= st;
            state_q <= md_start ? S_MD : S_OUT;
          end
        end
        S_MD: if (md_done) begin
          hi_q <= md_hi; lo_q <= md_lo; hi_value_o <= md_hi; lo_value_o <= md_lo;
          state_q <= S_OUT;
        end
        S_OUT: if (!out_valid_o || !out_stall_i) begin
          out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Operand read: registers, plus the memory word at the effective address; stores write that word in execute.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ins_q <= q_data_i;
      vs_q <= gpr_q[q_data_i.rs];
      vt_q <= gpr_q[q_data_i.rt];
    end
    if (state_q == S_RD) w_q <= dmem[AW'(r[31:2])];
    if (state_q == S_EX && !out_busy && !halted_q && mw) dmem[AW'(r[31:2])] <= md;
  end
endmodule

### hw/rtl/mips1_integer_execute.sv
// Top level of the MIPS I integer execute unit.
// Depends on mie_pkg, mie_front, mie_back and assert_macros.svh.
//
// Each instruction beat passes a two-entry queue and then the back-end steps in
// order (queue pop, operand and memory-word read, execute, result register);
// multiply and divide by a nonzero divisor also pass the bit-serial unit. The
// result register lets the next instruction be read while a result waits; that
// instruction then holds in execute until the waiting result beat is taken.
`include "assert_macros.svh"
module mips1_integer_execute #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  req_type_i,
  input  logic [4:0]  src_reg_s_i,
  input  logic [4:0]  src_reg_t_i,
  input  logic [4:0]  dest_reg_d_i,
  input  logic [4:0]  shift_amount_i,
  input  logic signed [15:0] immediate_i,
  input  logic [25:0] jump_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_fetch_pc_o,
  output logic        reg_write_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_write_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_data_o,
  output logic [31:0] hi_value_o,
  output logic [31:0] lo_value_o,
  output logic [1:0]  status_o
);
  import mie_pkg::*;

  logic q_valid, q_pop;
  dec_t q_data;

  assign cfg_ready_o = 1'b1;

  mie_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .op_i(req_type_i), .rs_i(src_reg_s_i), .rt_i(src_reg_t_i), .rd_i(dest_reg_d_i),
    .sa_i(shift_amount_i), .imm_i(immediate_i), .jidx_i(jump_index_i),
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  mie_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i(cfg_valid_i), .cfg_data_i,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .next_fetch_pc_o, .reg_write_o, .reg_index_o,
    .reg_value_o, .mem_write_o, .mem_address_o, .mem_data_o, .hi_value_o,
    .lo_value_o, .status_o
  );

  `ASSERT_IMPL(a_pop_valid, clk_i, rst_ni, q_pop |-> q_valid)
  `ASSERT_IMPL(a_r0_nowrite, clk_i, rst_ni, (out_valid_o && reg_write_o) |-> (reg_index_o != 5'd0))
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(next_fetch_pc_o))
endmodule
